### rtl/bac_pkg.sv
// Shared constants and register indexes for the battery activation controller.
`default_nettype none

package bac_pkg;

    // Slot count default and field widths
    localparam int SLOT_COUNT_DEF = 4;
    localparam int SLOT_IDX_W     = 2;
    localparam int VOLT_W         = 12;
    localparam int CUR_W          = 16;
    localparam int TIME_W         = 32;
    localparam int MA_W           = 8;
    localparam int THRESH_W       = 10;
    localparam int GAIN_W         = 16;
    localparam int OFFSET_W       = 16;
    localparam int DAC_CODE_W     = 11;
    localparam int PHASE_W        = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACT_CURRENT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_OFFSET   = 3'd4;

    // Register reset values
    localparam logic [TIME_W-1:0] DURATION_RST = 32'd10000;
    localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd1690;

    // Voltage limits for slot presence
    localparam logic [VOLT_W-1:0] VOLT_PRESENT = 12'd300;
    localparam logic [VOLT_W-1:0] VOLT_REMOVED = 12'd100;

    // Red lamp threshold scale
    localparam int RED_LIMIT_W = 17;
    localparam logic [RED_LIMIT_W-1:0] RED_SCALE = 17'd100;

    // DAC calibration: q = gain*mA + offset + 50, code = q/100 saturated
    localparam int Q_W = 26;
    localparam logic signed [Q_W-1:0] DAC_ROUND = 26'sd50;
    localparam logic signed [Q_W-1:0] DAC_SAT_Q = 26'sd204800;
    // q/100 as (q * ceil(2^25/100)) >> 25, exact for q below 204800
    localparam int DAC_QN_W    = 18;
    localparam int DAC_RECIP_W = 19;
    localparam int DAC_SHIFT   = 25;
    localparam logic [DAC_RECIP_W-1:0] DAC_RECIP = 19'd335545;
    localparam logic [DAC_CODE_W-1:0]  DAC_CODE_MAX = 11'd2047;

endpackage

`default_nettype wire

### rtl/bac_dac.sv
// DAC calibration: registered line value and rounded, saturated source code.
`default_nettype none

module bac_dac
(
    input  wire logic                                 clk,
    input  wire logic [bac_pkg::MA_W-1:0]             act_ma,
    input  wire logic [bac_pkg::GAIN_W-1:0]           dac_gain,
    input  wire logic signed [bac_pkg::OFFSET_W-1:0]  dac_offset,
    output logic      [bac_pkg::DAC_CODE_W-1:0]       act_code
);
    import bac_pkg::*;

    logic [GAIN_W+MA_W-1:0]            slope_prod;
    logic signed [Q_W-1:0]             q_next;
    logic signed [Q_W-1:0]             q_reg;
    logic [DAC_QN_W+DAC_RECIP_W-1:0]   scaled;

    // Form the calibrated line value from the configuration
    always_comb
    begin
        slope_prod = dac_gain * act_ma;
        q_next     = signed'({2'b00, slope_prod})
                   + Q_W'(dac_offset) + DAC_ROUND;
    end

    // Hold the line value; it follows the configuration in the next cycle
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // Divide by 100 through the reciprocal and saturate; zero for no current or negative q
    always_comb
    begin
        scaled = q_reg[DAC_QN_W-1:0] * DAC_RECIP;
        if (act_ma == '0 || q_reg < 0)
        begin
            act_code = '0;
        end
        else if (q_reg >= DAC_SAT_Q)
        begin
            act_code = DAC_CODE_MAX;
        end
        else
        begin
            act_code = scaled[DAC_SHIFT +: DAC_CODE_W];
        end
    end

endmodule

`default_nettype wire

### rtl/battery_activation_controller.sv
// Top level: slot phase machines, shared source control and lamp/DAC results.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | slot_index, voltage, current, now
//  out      | out_valid / out_stall| slot_echo, red_lit, yellow_lit, green_lit,
//           |                      | dac_write, dac_code, new_phase
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready always high)
//
//  One item per cycle while out_stall is low; an accepted item loads the input
//  register, then its slot update is loaded into the result register.
//  Slot state is read and written in the single update stage, so back-to-back
//  items on the same slot see each other's effects.
//  Reset clears all slot phases, elapsed and mark times and the source pause.
//  A stalled result holds; one more item waits in the input register.
`default_nettype none

module battery_activation_controller
#(
    parameter int SLOT_COUNT = bac_pkg::SLOT_COUNT_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // item input
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bac_pkg::SLOT_IDX_W-1:0]    slot_index,
    input  wire logic [bac_pkg::VOLT_W-1:0]        voltage,
    input  wire logic [bac_pkg::CUR_W-1:0]         current,
    input  wire logic [bac_pkg::TIME_W-1:0]        now,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bac_pkg::SLOT_IDX_W-1:0]         slot_echo,
    output logic                                   red_lit,
    output logic                                   yellow_lit,
    output logic                                   green_lit,
    output logic                                   dac_write,
    output logic [bac_pkg::DAC_CODE_W-1:0]         dac_code,
    output logic [bac_pkg::PHASE_W-1:0]            new_phase,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bac_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bac_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_EMPTY  = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_PAUSED = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // Configuration registers
    logic [MA_W-1:0]            act_ma_reg;
    logic [TIME_W-1:0]          duration_reg;
    logic [THRESH_W-1:0]        red_thresh_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [RED_LIMIT_W-1:0]     red_limit_reg;
    logic [DAC_CODE_W-1:0]      act_code;

    // Input register
    logic                       in_valid_reg;
    logic [SLOT_IDX_W-1:0]      slot_reg;
    logic [VOLT_W-1:0]          volt_reg;
    logic [CUR_W-1:0]           cur_reg;
    logic [TIME_W-1:0]          now_reg;

    // Slot state
    phase_t                     phase_reg [SLOT_COUNT];
    logic [TIME_W-1:0]          elapsed_reg [SLOT_COUNT];
    logic [TIME_W-1:0]          mark_reg [SLOT_COUNT];
    logic                       source_paused_reg;

    // Result register
    logic                       out_valid_reg;
    logic [SLOT_IDX_W-1:0]      slot_echo_reg;
    logic                       red_reg;
    logic                       yel_reg;
    logic                       grn_reg;
    logic                       wr_reg;
    logic [DAC_CODE_W-1:0]      code_reg;
    phase_t                     phase_out_reg;

    // Update stage
    logic                       advance;
    logic                       fire;
    logic                       in_range;
    logic                       any_done;
    logic                       any_busy;
    phase_t                     ph_cur;
    logic [TIME_W-1:0]          el_cur;
    logic [TIME_W-1:0]          mk_cur;
    phase_t                     phase_next;
    logic [TIME_W-1:0]          elapsed_next;
    logic [TIME_W-1:0]          mark_next;
    logic                       source_paused_next;
    logic [TIME_W:0]            el_sum;
    logic                       blink;
    logic                       red_next;
    logic                       yel_next;
    logic                       grn_next;
    logic                       wr_next;
    logic [DAC_CODE_W-1:0]      code_next;

    // Handshake control
    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_ma_reg     <= '0;
            duration_reg   <= DURATION_RST;
            red_thresh_reg <= '0;
            gain_reg       <= GAIN_RST;
            offset_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ACT_CURRENT:  act_ma_reg     <= cfg_data[MA_W-1:0];
                CFG_ACT_DURATION: duration_reg   <= cfg_data[TIME_W-1:0];
                CFG_RED_THRESH:   red_thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_DAC_GAIN:     gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_DAC_OFFSET:   offset_reg     <= signed'(cfg_data[OFFSET_W-1:0]);
                default:          ;
            endcase
        end
    end

    // Scale the red threshold into a registered limit
    always_ff @(posedge clk)
    begin
        red_limit_reg <= RED_LIMIT_W'(red_thresh_reg) * RED_SCALE;
    end

    // Source code for the activation current
    bac_dac u_dac
    (
        .clk        (clk),
        .act_ma     (act_ma_reg),
        .dac_gain   (gain_reg),
        .dac_offset (offset_reg),
        .act_code   (act_code)
    );

    // Capture an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            slot_reg <= slot_index;
            volt_reg <= voltage;
            cur_reg  <= current;
            now_reg  <= now;
        end
    end

    // Select the addressed slot and summarize all slots
    always_comb
    begin
        in_range = int'(slot_reg) < SLOT_COUNT;
        ph_cur   = PH_EMPTY;
        el_cur   = '0;
        mk_cur   = '0;
        any_done = 1'b0;
        any_busy = 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (int'(slot_reg) == k)
            begin
                ph_cur = phase_reg[k];
                el_cur = elapsed_reg[k];
                mk_cur = mark_reg[k];
            end
            if (phase_reg[k] == PH_DONE)
            begin
                any_done = 1'b1;
            end
            if (phase_reg[k] != PH_EMPTY)
            begin
                any_busy = 1'b1;
            end
        end
    end

    // Advance the addressed slot's phase machine
    always_comb
    begin
        blink              = ~now_reg[2];
        red_next           = {1'b0, cur_reg} > red_limit_reg;
        yel_next           = 1'b0;
        grn_next           = 1'b0;
        wr_next            = 1'b0;
        code_next          = '0;
        phase_next         = ph_cur;
        elapsed_next       = el_cur;
        mark_next          = mk_cur;
        source_paused_next = source_paused_reg;
        el_sum             = {1'b0, el_cur} + {1'b0, now_reg - mk_cur};

        // Restore the source once no slot is done
        if (source_paused_reg && !any_done)
        begin
            wr_next            = 1'b1;
            code_next          = act_code;
            source_paused_next = 1'b0;
        end

        case (ph_cur)
            PH_EMPTY:
            begin
                if (!any_busy)
                begin
                    source_paused_next = 1'b0;
                end
                if (volt_reg > VOLT_PRESENT)
                begin
                    elapsed_next = '0;
                    if (source_paused_next)
                    begin
                        phase_next = PH_PAUSED;
                        mark_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_ACTIVE;
                        mark_next  = now_reg;
                        wr_next    = 1'b1;
                        code_next  = act_code;
                    end
                end
            end
            PH_ACTIVE:
            begin
                yel_next     = 1'b1;
                elapsed_next = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
                mark_next    = now_reg;
                if (elapsed_next >= duration_reg)
                begin
                    phase_next         = PH_DONE;
                    wr_next            = 1'b1;
                    code_next          = '0;
                    source_paused_next = 1'b1;
                end
                else if (source_paused_next)
                begin
                    yel_next   = blink;
                    mark_next  = '0;
                    phase_next = PH_PAUSED;
                end
                else if (volt_reg < VOLT_PRESENT)
                begin
                    elapsed_next = '0;
                    phase_next   = PH_EMPTY;
                    mark_next    = '0;
                end
            end
            PH_PAUSED:
            begin
                yel_next = blink;
                if (volt_reg < VOLT_PRESENT)
                begin
                    elapsed_next = '0;
                    phase_next   = PH_EMPTY;
                    mark_next    = '0;
                end
                else if (!source_paused_next)
                begin
                    phase_next = PH_ACTIVE;
                    mark_next  = now_reg;
                end
            end
            default:
            begin
                // done: green stays lit until the battery is pulled
                grn_next = 1'b1;
                if (volt_reg < VOLT_REMOVED)
                begin
                    phase_next = PH_EMPTY;
                end
            end
        endcase
    end

    // Commit slot state for an in-range item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                phase_reg[k]   <= PH_EMPTY;
                elapsed_reg[k] <= '0;
                mark_reg[k]    <= '0;
            end
            source_paused_reg <= 1'b0;
        end
        else if (fire && in_range)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                if (int'(slot_reg) == k)
                begin
                    phase_reg[k]   <= phase_next;
                    elapsed_reg[k] <= elapsed_next;
                    mark_reg[k]    <= mark_next;
                end
            end
            source_paused_reg <= source_paused_next;
        end
    end

    // Load the result register; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot_echo_reg <= slot_reg;
            red_reg       <= in_range && red_next;
            yel_reg       <= in_range && yel_next;
            grn_reg       <= in_range && grn_next;
            wr_reg        <= in_range && wr_next;
            code_reg      <= (in_range && wr_next) ? code_next : '0;
            phase_out_reg <= in_range ? phase_next : PH_EMPTY;
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_echo  = slot_echo_reg;
    assign red_lit    = red_reg;
    assign yellow_lit = yel_reg;
    assign green_lit  = grn_reg;
    assign dac_write  = wr_reg;
    assign dac_code   = code_reg;
    assign new_phase  = phase_out_reg;

    // Slot 0 in the done phase always has the source paused
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg[0] == PH_DONE) |-> source_paused_reg)
        else $error("slot done while source not paused");

    // No code without a DAC write
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !dac_write) |-> (dac_code == '0))
        else $error("dac_code set without dac_write");

    // A write in the done phase can only be the cut to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dac_write && new_phase == PH_DONE) |-> (dac_code == '0))
        else $error("nonzero code on slot completion");

    // Ignored slots report nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && int'(slot_echo) >= SLOT_COUNT)
            |-> (!dac_write && new_phase == PH_EMPTY && !red_lit))
        else $error("out-of-range slot produced a result");

endmodule

`default_nettype wire
